[hw/rtl/dts_pkg.sv]
// Shared types and codes for the disk transfer sequencer.
// Used by dts_step_unit, dts_sequencer and disk_transfer_sequencer_top.
package dts_pkg;

   // result kinds
   localparam logic [1:0] KIND_SEEK     = 2'd0;
   localparam logic [1:0] KIND_READ     = 2'd1;
   localparam logic [1:0] KIND_WRITE    = 2'd2;
   localparam logic [1:0] KIND_COMPLETE = 2'd3;

   // completion status codes
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_BAD_UNIT  = 3'd1;
   localparam logic [2:0] STAT_BAD_TRACK = 3'd2;
   localparam logic [2:0] STAT_BAD_FIRST = 3'd3;
   localparam logic [2:0] STAT_NULL_BUF  = 3'd4;
   localparam logic [2:0] STAT_PAST_END  = 3'd5;

   // csr register indexes
   localparam logic [1:0] CSR_UNIT_COUNT = 2'd0;
   localparam logic [1:0] CSR_TRACKS_U0  = 2'd1;
   localparam logic [1:0] CSR_TRACKS_U1  = 2'd2;

   // result slots per request; the completion always takes the last one
   localparam int MAX_RESULTS = 36;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEEK,
      ST_XFER,
      ST_NEXT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  unit_count;
      logic [10:0] tracks_u0;
      logic [10:0] tracks_u1;
   } cfg_type;

   // shared add/compare unit: sum = a + b, ge = (sum >= lim)
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [10:0] lim;
   } step_op_type;

   typedef struct packed {
      logic [31:0] sum;
      logic        ge;
   } step_res_type;

endpackage

[hw/rtl/dts_step_unit.sv]
// Shared 32-bit adder with limit compare for the transfer sequencer.
// Depends on dts_pkg for the operand and result structs.
module dts_step_unit
   import dts_pkg::*;
(
   input  step_op_type  op,
   output step_res_type res
);

   logic [31:0] sum;

   assign sum     = op.a + op.b;
   assign res.sum = sum;
   assign res.ge  = (sum >= 32'(op.lim));

endmodule

[hw/rtl/dts_sequencer.sv]
// Request check and command sequencer with output register.
// Depends on dts_pkg and dts_step_unit (shared add/compare).
module dts_sequencer
   import dts_pkg::*;
#(
   parameter int TRACK_SECTORS = 16,
   parameter int SECTOR_BYTES  = 512,
   parameter int MAX_SECTORS   = 32,
   parameter int MAX_TRACKS    = 1024,
   parameter int UNITS         = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_unit,
   input  logic        req_is_write,
   input  logic [9:0]  req_start_track,
   input  logic [7:0]  req_first_sector,
   input  logic [5:0]  req_sector_count,
   input  logic [31:0] req_buffer_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [9:0]  rsp_track_number,
   output logic [3:0]  rsp_sector_index,
   output logic [31:0] rsp_memory_address,
   output logic [2:0]  rsp_status,
   output logic        rsp_last
);

   localparam int IDX_W = $clog2(TRACK_SECTORS + 1);

   state_type            state_ff, state_in;
   logic [1:0]           unit_ff, unit_in;
   logic                 write_ff, write_in;
   logic [10:0]          cur_ff, cur_in;
   logic [10:0]          tracks_ff, tracks_in;
   logic [7:0]           first_ff, first_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [5:0]           left_ff, left_in;
   logic [31:0]          addr_ff, addr_in;
   logic [2:0]           status_ff, status_in;
   logic [RES_CNT_W-1:0] nres_ff, nres_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff;
   logic [9:0]  track_ff;
   logic [3:0]  sector_ff;
   logic [31:0] maddr_ff;
   logic [2:0]  stat_ff;
   logic        last_ff;

   logic        emit;
   logic [1:0]  e_kind;
   logic [9:0]  e_track;
   logic [3:0]  e_sector;
   logic [31:0] e_addr;
   logic [2:0]  e_status;
   logic        e_last;

   logic         emit_ok;
   logic         room;
   logic         go;
   logic [1:0]   units_eff;
   logic [10:0]  trk_sel;
   logic [10:0]  trk_lim;
   step_op_type  op;
   step_res_type res;

   dts_step_unit u_step (
      .op  (op),
      .res (res)
   );

   assign emit_ok   = !rsp_valid_ff || rsp_ready;
   // non-completion results stop one short of the slot limit
   assign room      = (nres_ff < RES_CNT_W'(MAX_RESULTS - 1));
   assign go        = !room || emit_ok;
   assign units_eff = (32'(cfg.unit_count) > 32'(UNITS)) ? 2'(UNITS) : cfg.unit_count;
   assign trk_sel   = (unit_ff == 2'd0) ? cfg.tracks_u0 : cfg.tracks_u1;
   assign trk_lim   = (32'(trk_sel) > 32'(MAX_TRACKS)) ? 11'(MAX_TRACKS) : trk_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      unit_in   = unit_ff;
      write_in  = write_ff;
      cur_in    = cur_ff;
      tracks_in = tracks_ff;
      first_in  = first_ff;
      idx_in    = idx_ff;
      left_in   = left_ff;
      addr_in   = addr_ff;
      status_in = status_ff;
      nres_in   = nres_ff;
      req_ready = 1'b0;
      emit      = 1'b0;
      e_kind    = KIND_COMPLETE;
      e_track   = '0;
      e_sector  = '0;
      e_addr    = '0;
      e_status  = STAT_OK;
      e_last    = 1'b0;
      op.a      = addr_ff;
      op.b      = 32'(SECTOR_BYTES);
      op.lim    = tracks_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unit_in   = req_unit;
               write_in  = req_is_write;
               cur_in    = {1'b0, req_start_track};
               first_in  = req_first_sector;
               addr_in   = req_buffer_address;
               left_in   = (32'(req_sector_count) > 32'(MAX_SECTORS)) ?
                           6'(MAX_SECTORS) : req_sector_count;
               status_in = STAT_OK;
               nres_in   = '0;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // track range check runs through the shared unit with b = 0
            op.a      = 32'(cur_ff);
            op.b      = '0;
            op.lim    = trk_lim;
            tracks_in = trk_lim;
            idx_in    = IDX_W'(first_ff);
            priority if (unit_ff >= units_eff) begin
               status_in = STAT_BAD_UNIT;
               state_in  = ST_DONE;
            end else if (res.ge) begin
               status_in = STAT_BAD_TRACK;
               state_in  = ST_DONE;
            end else if (32'(first_ff) >= 32'(TRACK_SECTORS)) begin
               status_in = STAT_BAD_FIRST;
               state_in  = ST_DONE;
            end else if (addr_ff == 32'd0) begin
               status_in = STAT_NULL_BUF;
               state_in  = ST_DONE;
            end else begin
               state_in  = ST_SEEK;
            end
         end
         ST_SEEK: begin
            e_kind  = KIND_SEEK;
            e_track = cur_ff[9:0];
            emit    = room && emit_ok;
            if (emit) begin
               nres_in = nres_ff + 1'b1;
            end
            if (go) begin
               state_in = (left_ff == 6'd0) ? ST_DONE : ST_XFER;
            end
         end
         ST_XFER: begin
            if (idx_ff == IDX_W'(TRACK_SECTORS)) begin
               state_in = ST_NEXT;
            end else begin
               e_kind   = write_ff ? KIND_WRITE : KIND_READ;
               e_track  = cur_ff[9:0];
               e_sector = 4'(idx_ff);
               e_addr   = addr_ff;
               emit     = room && emit_ok;
               if (emit) begin
                  nres_in = nres_ff + 1'b1;
               end
               if (go) begin
                  addr_in  = res.sum;
                  idx_in   = idx_ff + 1'b1;
                  left_in  = left_ff - 1'b1;
                  state_in = (left_ff == 6'd1) ? ST_DONE : ST_XFER;
               end
            end
         end
         ST_NEXT: begin
            op.a   = 32'(cur_ff);
            op.b   = 32'd1;
            op.lim = tracks_ff;
            cur_in = res.sum[10:0];
            if (res.ge) begin
               status_in = STAT_PAST_END;
               state_in  = ST_DONE;
            end else begin
               idx_in   = '0;
               state_in = ST_SEEK;
            end
         end
         ST_DONE: begin
            e_kind   = KIND_COMPLETE;
            e_status = status_ff;
            e_last   = 1'b1;
            emit     = emit_ok;
            if (emit_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      unit_ff   <= unit_in;
      write_ff  <= write_in;
      cur_ff    <= cur_in;
      tracks_ff <= tracks_in;
      first_ff  <= first_in;
      idx_ff    <= idx_in;
      left_ff   <= left_in;
      addr_ff   <= addr_in;
      status_ff <= status_in;
      nres_ff   <= nres_in;
   end

   // output register
   assign rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff   <= e_kind;
         track_ff  <= e_track;
         sector_ff <= e_sector;
         maddr_ff  <= e_addr;
         stat_ff   <= e_status;
         last_ff   <= e_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_track_number   = track_ff;
   assign rsp_sector_index   = sector_ff;
   assign rsp_memory_address = maddr_ff;
   assign rsp_status         = stat_ff;
   assign rsp_last           = last_ff;

   a_one_req_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a run is in progress");

   a_result_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_CHECK) |->
         (nres_ff <= RES_CNT_W'(MAX_RESULTS - 1)))
      else $error("command count passed the result limit");

   a_xfer_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_XFER || state_ff == ST_SEEK) |-> (cur_ff < tracks_ff))
      else $error("transfer on a track past the unit's end");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_XFER) |-> (32'(idx_ff) <= 32'(TRACK_SECTORS)))
      else $error("sector index beyond track size");

   a_seek_fixed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_SEEK) |->
         (rsp_sector_index == 4'd0 && rsp_memory_address == 32'd0 && !rsp_last))
      else $error("seek carries sector or address");

endmodule

[hw/rtl/disk_transfer_sequencer_top.sv]
// Disk transfer sequencer: one request becomes a seek, per-sector commands and a completion.
// An accepted request passes the check state; the first command, or a failed check's
// completion, then leaves through the output register. Commands follow one per cycle
// while rsp_ready is high; a track change passes an end-of-track step and ST_NEXT with
// no command. One request at a time; single 32-bit add/compare unit. Reset: synchronous,
// active high; clears sequencer, output valid and csr regs. Needs dts_pkg, dts_sequencer.
module disk_transfer_sequencer_top
   import dts_pkg::*;
#(
   parameter int TRACK_SECTORS = 16,
   parameter int SECTOR_BYTES  = 512,
   parameter int MAX_SECTORS   = 32,
   parameter int MAX_TRACKS    = 1024,
   parameter int UNITS         = 2
) (
   input  logic        clock,
   input  logic        reset,
   // csr write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_unit,
   input  logic        req_is_write,
   input  logic [9:0]  req_start_track,
   input  logic [7:0]  req_first_sector,
   input  logic [5:0]  req_sector_count,
   input  logic [31:0] req_buffer_address,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [9:0]  rsp_track_number,
   output logic [3:0]  rsp_sector_index,
   output logic [31:0] rsp_memory_address,
   output logic [2:0]  rsp_status,
   output logic        rsp_last
);

   logic [1:0]  unit_count_ff, unit_count_in;
   logic [10:0] tracks_u0_ff, tracks_u0_in;
   logic [10:0] tracks_u1_ff, tracks_u1_in;
   cfg_type     cfg;

   // csr writes are always taken; an unknown index is dropped
   assign csr_ready = 1'b1;

   always_comb begin
      unit_count_in = unit_count_ff;
      tracks_u0_in  = tracks_u0_ff;
      tracks_u1_in  = tracks_u1_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_UNIT_COUNT: unit_count_in = csr_data[1:0];
            CSR_TRACKS_U0:  tracks_u0_in  = csr_data;
            CSR_TRACKS_U1:  tracks_u1_in  = csr_data;
            default: begin
               unit_count_in = unit_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_count_ff <= '0;
         tracks_u0_ff  <= '0;
         tracks_u1_ff  <= '0;
      end else begin
         unit_count_ff <= unit_count_in;
         tracks_u0_ff  <= tracks_u0_in;
         tracks_u1_ff  <= tracks_u1_in;
      end
   end

   assign cfg.unit_count = unit_count_ff;
   assign cfg.tracks_u0  = tracks_u0_ff;
   assign cfg.tracks_u1  = tracks_u1_ff;

   // check, seek/transfer sequencing and the output register all live here;
   // ready is high only between runs
   dts_sequencer #(
      .TRACK_SECTORS (TRACK_SECTORS),
      .SECTOR_BYTES  (SECTOR_BYTES),
      .MAX_SECTORS   (MAX_SECTORS),
      .MAX_TRACKS    (MAX_TRACKS),
      .UNITS         (UNITS)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_unit           (req_unit),
      .req_is_write       (req_is_write),
      .req_start_track    (req_start_track),
      .req_first_sector   (req_first_sector),
      .req_sector_count   (req_sector_count),
      .req_buffer_address (req_buffer_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_track_number   (rsp_track_number),
      .rsp_sector_index   (rsp_sector_index),
      .rsp_memory_address (rsp_memory_address),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last)
   );

endmodule
